// ===== design/sgr_pkg.sv =====
`timescale 1ns / 1ps
package sgr_pkg;

    localparam int MAX_CODES  = 16;
    localparam int CODE_CNT_W = $clog2(MAX_CODES + 1);

    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_SEMI     = 8'h3B;
    localparam logic [7:0] CHAR_M        = 8'h6D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [4:0] DEFAULT_COLOR = 5'd16;
    localparam logic [6:0] NUM_SAT       = 7'd127;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } sgr_in_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [4:0] fg_color;
        logic [4:0] bg_color;
        logic [7:0] attr_bits;
        logic       run_last;
    } sgr_out_t;

    typedef struct packed {
        logic [1:0] count;
        sgr_out_t   res0;
        sgr_out_t   res1;
    } sgr_step_t;

endpackage

// ===== design/sgr_parser.sv =====
`timescale 1ns / 1ps
module sgr_parser
    import sgr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_valid,
    input  sgr_in_t   step_item,
    output sgr_step_t step_res
);

    typedef enum logic [3:0] {
        MODE_TEXT = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_CSI  = 4'b0100,
        MODE_SKIP = 4'b1000
    } sgr_mode_t;

    typedef struct packed {
        logic [4:0] fg;
        logic [4:0] bg;
        logic [7:0] attrs;
    } sgr_look_t;

    function automatic sgr_look_t apply_code(input logic [6:0] code, input sgr_look_t cur);
        sgr_look_t  r;
        logic [2:0] bit_idx;
        r = cur;
        bit_idx = 3'd0;
        if (code == 7'd0) begin
            r.fg = DEFAULT_COLOR;
            r.bg = DEFAULT_COLOR;
            r.attrs = 8'd0;
        end else if (code >= 7'd1 && code <= 7'd5) begin
            bit_idx = 3'(code - 7'd1);
            r.attrs = cur.attrs | (8'd1 << bit_idx);
        end else if (code >= 7'd7 && code <= 7'd9) begin
            bit_idx = 3'(code - 7'd2);
            r.attrs = cur.attrs | (8'd1 << bit_idx);
        end else if (code == 7'd22) begin
            r.attrs = cur.attrs & 8'hFC;
        end else if (code >= 7'd23 && code <= 7'd25) begin
            bit_idx = 3'(code - 7'd21);
            r.attrs = cur.attrs & ~(8'd1 << bit_idx);
        end else if (code >= 7'd27 && code <= 7'd29) begin
            bit_idx = 3'(code - 7'd22);
            r.attrs = cur.attrs & ~(8'd1 << bit_idx);
        end else if (code >= 7'd30 && code <= 7'd37) begin
            r.fg = 5'(code - 7'd30);
            r.attrs = cur.attrs & 8'hFD;
        end else if (code >= 7'd90 && code <= 7'd97) begin
            r.fg = 5'(code - 7'd82);
            r.attrs = cur.attrs & 8'hFD;
        end else if (code == 7'd39) begin
            r.fg = DEFAULT_COLOR;
        end else if (code >= 7'd40 && code <= 7'd47) begin
            r.bg = 5'(code - 7'd40);
        end else if (code >= 7'd100 && code <= 7'd107) begin
            r.bg = 5'(code - 7'd92);
        end else if (code == 7'd49) begin
            r.bg = DEFAULT_COLOR;
        end
        return r;
    endfunction

    localparam sgr_look_t LOOK_RESET = '{fg: DEFAULT_COLOR, bg: DEFAULT_COLOR, attrs: 8'd0};

    sgr_mode_t             mode_reg, mode_next;
    logic [6:0]            accum_reg, accum_next;
    logic                  in_num_reg, in_num_next;
    logic [CODE_CNT_W-1:0] cnt_reg, cnt_next;
    sgr_look_t             live_reg, live_next;
    sgr_look_t             work_reg, work_next;

    logic [7:0]            b;
    logic                  is_digit;
    logic [10:0]           digit_val;
    logic [CODE_CNT_W-1:0] cnt_inc;
    sgr_look_t             work_applied;
    logic                  emit_esc_first;
    logic                  emit_b;
    logic                  emit_esc_end;
    logic [1:0]            n_res;

    assign b         = step_item.in_byte;
    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit_val = {4'd0, accum_reg} * 11'd10 + {7'd0, b[3:0]};
    assign cnt_inc   = cnt_reg + 1'b1;
    assign work_applied = apply_code(accum_reg, work_reg);

    always_comb begin
        mode_next      = mode_reg;
        accum_next     = accum_reg;
        in_num_next    = in_num_reg;
        cnt_next       = cnt_reg;
        live_next      = live_reg;
        work_next      = work_reg;
        emit_esc_first = 1'b0;
        emit_b         = 1'b0;
        emit_esc_end   = 1'b0;

        case (mode_reg)
            MODE_TEXT: begin
                if (b == ESC_BYTE) begin
                    mode_next = MODE_ESC;
                end else begin
                    emit_b = 1'b1;
                end
            end
            MODE_ESC: begin
                if (b == CHAR_LBRACKET) begin
                    mode_next   = MODE_CSI;
                    work_next   = live_reg;
                    cnt_next    = '0;
                    accum_next  = 7'd0;
                    in_num_next = 1'b0;
                end else begin
                    emit_esc_first = 1'b1;
                    if (b == ESC_BYTE) begin
                        mode_next = MODE_ESC;
                    end else begin
                        mode_next = MODE_TEXT;
                        emit_b    = 1'b1;
                    end
                end
            end
            MODE_CSI: begin
                if (is_digit) begin
                    accum_next  = (digit_val > {4'd0, NUM_SAT}) ? NUM_SAT : digit_val[6:0];
                    in_num_next = 1'b1;
                end else begin
                    if (in_num_reg) begin
                        work_next   = work_applied;
                        accum_next  = 7'd0;
                        in_num_next = 1'b0;
                        cnt_next    = cnt_inc;
                    end
                    if (in_num_reg && cnt_inc >= CODE_CNT_W'(MAX_CODES)) begin
                        live_next = work_applied;
                        if (b == ESC_BYTE) begin
                            mode_next = MODE_ESC;
                        end else begin
                            mode_next = MODE_TEXT;
                            emit_b    = 1'b1;
                        end
                    end else if (b == CHAR_SEMI) begin
                        mode_next = MODE_CSI;
                    end else if (b == CHAR_M) begin
                        live_next = work_next;
                        mode_next = MODE_TEXT;
                    end else begin
                        mode_next = MODE_SKIP;
                    end
                end
            end
            default: begin
                if (b == CHAR_M) begin
                    mode_next = MODE_TEXT;
                end
            end
        endcase

        if (step_item.end_of_text) begin
            emit_esc_end = (mode_next == MODE_ESC);
        end
    end

    assign n_res = 2'(emit_esc_first) + 2'(emit_b) + 2'(emit_esc_end);

    always_comb begin
        step_res = '0;
        step_res.count = step_valid ? n_res : 2'd0;
        step_res.res0.text_byte = emit_esc_first ? ESC_BYTE : (emit_b ? b : ESC_BYTE);
        step_res.res0.fg_color  = live_next.fg;
        step_res.res0.bg_color  = live_next.bg;
        step_res.res0.attr_bits = live_next.attrs;
        step_res.res0.run_last  = (n_res == 2'd1);
        step_res.res1.text_byte = (emit_esc_first && emit_b) ? b : ESC_BYTE;
        step_res.res1.fg_color  = live_next.fg;
        step_res.res1.bg_color  = live_next.bg;
        step_res.res1.attr_bits = live_next.attrs;
        step_res.res1.run_last  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TEXT;
            accum_reg  <= 7'd0;
            in_num_reg <= 1'b0;
            cnt_reg    <= '0;
            live_reg   <= LOOK_RESET;
            work_reg   <= LOOK_RESET;
        end else if (step_valid) begin
            if (step_item.end_of_text) begin
                mode_reg   <= MODE_TEXT;
                accum_reg  <= 7'd0;
                in_num_reg <= 1'b0;
                cnt_reg    <= '0;
                live_reg   <= LOOK_RESET;
                work_reg   <= LOOK_RESET;
            end else begin
                mode_reg   <= mode_next;
                accum_reg  <= accum_next;
                in_num_reg <= in_num_next;
                cnt_reg    <= cnt_next;
                live_reg   <= live_next;
                work_reg   <= work_next;
            end
        end
    end

endmodule

// ===== design/sgr_out_fifo.sv =====
`timescale 1ns / 1ps
module sgr_out_fifo
    import sgr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sgr_step_t push,
    output logic      room_two,
    output logic      m_valid,
    input  logic      m_ready,
    output sgr_out_t  m_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    sgr_out_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign m_valid      = (count_reg != '0);
    assign m_item       = mem[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign room_two     = (count_reg <= (PTR_W + 1)'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/sgr_escape_attribute_tracker_core.sv =====
`timescale 1ns / 1ps
// Tags each plain text byte with the current foreground index, background index
// and eight attribute bits while following ESC [ ... m sequences in the stream;
// sequence bytes produce no item, a lone ESC is passed as text, and the byte
// marked end_of_text returns all state to reset. One byte is accepted per clock
// while the queue has room: a byte is held in the input register while the parser
// updates its state and writes zero, one or two result items into a four-entry
// output queue, from which the results are offered. Input stalls only while the
// queue cannot take two more items.
module sgr_escape_attribute_tracker_core
    import sgr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sgr_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output sgr_out_t m_item
);

    logic      in_valid_reg;
    sgr_in_t   in_item_reg;
    logic      room_two;
    logic      advance;
    sgr_step_t step_res;

    assign advance = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    sgr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .step_item  (in_item_reg),
        .step_res   (step_res)
    );

    sgr_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (step_res),
        .room_two (room_two),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== sim/tb_sgr_escape_attribute_tracker_core.sv =====
`timescale 1ns / 1ps
module tb_sgr_escape_attribute_tracker_core;
    import sgr_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 10;
    localparam int ITEM_TARGET = 1900;
    localparam int IDLE_PCT    = 17;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TICKS = 10;

    typedef enum logic [1:0] {
        PM_TEXT,
        PM_ESC,
        PM_CSI,
        PM_SKIP
    } parse_mode_t;

    class sgr_tag_tracker;
        parse_mode_t mode;
        logic [6:0]  num_acc;
        logic        in_num;
        int          code_cnt;
        logic [4:0]  live_fg;
        logic [4:0]  live_bg;
        logic [7:0]  live_attrs;
        logic [4:0]  work_fg;
        logic [4:0]  work_bg;
        logic [7:0]  work_attrs;
        sgr_out_t    step_tags[$];
        sgr_out_t    tagged_bytes_q[$];
        int          err_count;

        function new();
            err_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode       = PM_TEXT;
            num_acc    = '0;
            in_num     = 1'b0;
            code_cnt   = 0;
            live_fg    = DEFAULT_COLOR;
            live_bg    = DEFAULT_COLOR;
            live_attrs = '0;
            work_fg    = DEFAULT_COLOR;
            work_bg    = DEFAULT_COLOR;
            work_attrs = '0;
        endfunction

        function int pending();
            return tagged_bytes_q.size();
        endfunction

        function void apply_code(int code);
            if (code == 0) begin
                work_fg    = DEFAULT_COLOR;
                work_bg    = DEFAULT_COLOR;
                work_attrs = '0;
            end else if (code >= 1 && code <= 5) begin
                work_attrs[code - 1] = 1'b1;
            end else if (code >= 7 && code <= 9) begin
                work_attrs[code - 2] = 1'b1;
            end else if (code == 22) begin
                work_attrs[1:0] = 2'b00;
            end else if (code >= 23 && code <= 25) begin
                work_attrs[code - 21] = 1'b0;
            end else if (code >= 27 && code <= 29) begin
                work_attrs[code - 22] = 1'b0;
            end else if (code >= 30 && code <= 37) begin
                work_fg       = 5'(code - 30);
                work_attrs[1] = 1'b0;
            end else if (code >= 90 && code <= 97) begin
                work_fg       = 5'(code - 82);
                work_attrs[1] = 1'b0;
            end else if (code == 39) begin
                work_fg = DEFAULT_COLOR;
            end else if (code >= 40 && code <= 47) begin
                work_bg = 5'(code - 40);
            end else if (code >= 100 && code <= 107) begin
                work_bg = 5'(code - 92);
            end else if (code == 49) begin
                work_bg = DEFAULT_COLOR;
            end
        endfunction

        function void commit_work();
            live_fg    = work_fg;
            live_bg    = work_bg;
            live_attrs = work_attrs;
        endfunction

        function void tag_byte(logic [7:0] b);
            sgr_out_t t;
            t.text_byte = b;
            t.fg_color  = live_fg;
            t.bg_color  = live_bg;
            t.attr_bits = live_attrs;
            t.run_last  = 1'b0;
            step_tags.push_back(t);
        endfunction

        function void take_text(logic [7:0] b);
            if (b == ESC_BYTE) begin
                mode = PM_ESC;
            end else begin
                mode = PM_TEXT;
                tag_byte(b);
            end
        endfunction

        task take_byte(sgr_in_t it);
            logic [7:0] b;
            int         sum;
            bit         done;
            b = it.in_byte;
            step_tags.delete();
            case (mode)
                PM_TEXT: begin
                    take_text(b);
                end
                PM_ESC: begin
                    if (b == CHAR_LBRACKET) begin
                        mode       = PM_CSI;
                        work_fg    = live_fg;
                        work_bg    = live_bg;
                        work_attrs = live_attrs;
                        code_cnt   = 0;
                        num_acc    = '0;
                        in_num     = 1'b0;
                    end else begin
                        tag_byte(ESC_BYTE);
                        take_text(b);
                    end
                end
                PM_CSI: begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        sum     = int'(num_acc) * 10 + int'(b) - int'(CHAR_ZERO);
                        num_acc = (sum > int'(NUM_SAT)) ? NUM_SAT : 7'(sum);
                        in_num  = 1'b1;
                    end else begin
                        done = 1'b0;
                        if (in_num) begin
                            apply_code(int'(num_acc));
                            num_acc  = '0;
                            in_num   = 1'b0;
                            code_cnt = code_cnt + 1;
                            if (code_cnt >= MAX_CODES) begin
                                commit_work();
                                take_text(b);
                                done = 1'b1;
                            end
                        end
                        if (!done) begin
                            if (b == CHAR_M) begin
                                commit_work();
                                mode = PM_TEXT;
                            end else if (b != CHAR_SEMI) begin
                                mode = PM_SKIP;
                            end
                        end
                    end
                end
                default: begin
                    if (b == CHAR_M) mode = PM_TEXT;
                end
            endcase
            if (it.end_of_text) begin
                if (mode == PM_ESC) tag_byte(ESC_BYTE);
                clear_state();
            end
            if (step_tags.size() > 0) step_tags[step_tags.size() - 1].run_last = 1'b1;
            foreach (step_tags[i]) tagged_bytes_q.push_back(step_tags[i]);
        endtask

        task report_mismatch(string what);
            err_count++;
            if (err_count <= 100) $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_tagged(sgr_out_t got);
            sgr_out_t want;
            if (tagged_bytes_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", got));
            end else begin
                want = tagged_bytes_q.pop_front();
                if (got.text_byte !== want.text_byte)
                    report_mismatch($sformatf("text_byte got %h want %h",
                                              got.text_byte, want.text_byte));
                if (got.fg_color !== want.fg_color)
                    report_mismatch($sformatf("fg_color got %0d want %0d (byte %h)",
                                              got.fg_color, want.fg_color, want.text_byte));
                if (got.bg_color !== want.bg_color)
                    report_mismatch($sformatf("bg_color got %0d want %0d (byte %h)",
                                              got.bg_color, want.bg_color, want.text_byte));
                if (got.attr_bits !== want.attr_bits)
                    report_mismatch($sformatf("attr_bits got %b want %b (byte %h)",
                                              got.attr_bits, want.attr_bits, want.text_byte));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last got %b want %b (byte %h)",
                                              got.run_last, want.run_last, want.text_byte));
            end
        endtask
    endclass

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sgr_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    sgr_out_t m_item;

    sgr_tag_tracker tracker;
    bit             calm = 1'b0;
    int             sent_cnt = 0;
    int             quiet_cycles = 0;

    sgr_escape_attribute_tracker_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.take_byte(s_item);
            if (m_valid && m_ready) tracker.check_tagged(m_item);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL sgr_escape_attribute_tracker_core");
                $finish;
            end
        end
    end

    task send_byte(logic [7:0] b, logic eot);
        sgr_in_t it;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        it.in_byte     = b;
        it.end_of_text = eot;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        calm = (sent_cnt >= 700 && sent_cnt < 1000);
    endtask

    task send_str(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    function bit rare_eot();
        return $urandom_range(0, 199) == 0;
    endfunction

    function int pick_code();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(21, 29);
            2:       return $urandom_range(30, 39);
            3:       return $urandom_range(40, 49);
            4:       return $urandom_range(90, 97);
            5:       return $urandom_range(100, 107);
            6:       return $urandom_range(0, 127);
            default: return $urandom_range(128, 999);
        endcase
    endfunction

    task send_number(int v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0) send_byte(CHAR_ZERO, rare_eot());
        for (int i = 0; i < digits.len(); i++) send_byte(digits[i], rare_eot());
    endtask

    task send_sgr(bit broken);
        int n;
        int junk_at;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        junk_at = broken ? $urandom_range(0, n) : -1;
        send_byte(ESC_BYTE, rare_eot());
        send_byte(CHAR_LBRACKET, rare_eot());
        for (int i = 0; i <= n; i++) begin
            if (i == junk_at) begin
                send_byte(8'($urandom_range(0, 255)), rare_eot());
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            if (i == n) break;
            if (i > 0) send_byte(CHAR_SEMI, rare_eot());
            if ($urandom_range(0, 9) == 0) send_byte(CHAR_SEMI, rare_eot());
            send_number(pick_code());
        end
        send_byte(CHAR_M, rare_eot());
    endtask

    task send_text_run();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), (i == n - 1) && ($urandom_range(0, 9) == 0));
    endtask

    initial begin
        int pick;
        tracker = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        m_ready <= 1'b0;
        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_str("\033x\033\033[;m\033[999mQ\033[5Zm");
        send_byte(ESC_BYTE, 1'b1);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(CHAR_LBRACKET, 1'b0);
        send_byte(CHAR_ZERO + 8'd3, 1'b1);

        while (sent_cnt < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_sgr(1'b0);
            end else if (pick < 75) begin
                send_text_run();
            end else if (pick < 85) begin
                send_byte(ESC_BYTE, 1'b0);
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end else if (pick < 95) begin
                send_sgr(1'b1);
            end else begin
                send_byte(ESC_BYTE, 1'b0);
                send_byte(ESC_BYTE, $urandom_range(0, 3) == 0);
            end
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
        if (tracker.err_count == 0)
            $display("PASS sgr_escape_attribute_tracker_core");
        else
            $display("FAIL sgr_escape_attribute_tracker_core");
        $finish;
    end

endmodule
